@@ sv/se2pau_pkg.sv @@
`default_nettype none

package se2pau_pkg;

    // fixed field widths of the item and result beats
    localparam int FIELD_W = 32;
    localparam int OP_W    = 3;

    // full-precision product and accumulated sum widths
    localparam int PROD_W = 2 * FIELD_W;
    localparam int SUM_W  = PROD_W + 3;

    // number of result words and product terms per word
    localparam int N_WORDS = 4;
    localparam int N_TERMS = 4;

    // parameter defaults
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_COMPOSE     = 3'd0,
        OP_COMPOSE_INV = 3'd1,
        OP_POINT       = 3'd2,
        OP_POINT_INV   = 3'd3,
        OP_ADJ         = 3'd4,
        OP_ADJ_T       = 3'd5
    } op_t;

    typedef logic signed [FIELD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

`default_nettype wire

@@ sv/se2_pose_arithmetic_unit.sv @@
`default_nettype none

// planar rigid pose arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// item channel: drive opcode, pose a_* and operand b_word0..3 with start high; the item
//   is taken at any rising edge with start high and busy low (busy is always low)
// result channel: done is high for exactly one cycle with res_word0..3 and saturated;
//   the beat is taken at the edge that ends that cycle and cannot be held off
// order: done rises once the beat has passed the s1..s5 registers and the output register,
//   and result beats come out in item order
// throughput: one item per cycle, set by the six-stage register pipeline
//   stage 1  operand select and up to sixteen 32x32 products
//   stage 2  signed sum of products, added word and rounding half
//   stage 3  rounding shift and saturation
//   stage 4  products on the rounded rotation (compose inverse translation)
//   stage 5  second sum, stage 6 second round/saturate and output register
// each word is rounded once, half toward plus infinity, then clipped to
//   min(WORD_BITS, 32) bits; saturated flags any clipped word
// reserved opcodes give all-zero words and saturated low
// reset clears only the valid bits; no beat comes out until items go in
module se2_pose_arithmetic_unit #(
    parameter int WORD_BITS = se2pau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = se2pau_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [se2pau_pkg::OP_W-1:0]       opcode,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] a_rot0,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] a_rot1,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] a_trans0,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] a_trans1,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] b_word0,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] b_word1,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] b_word2,
    input  logic signed [se2pau_pkg::FIELD_W-1:0] b_word3,
    output logic                              done,
    output logic signed [se2pau_pkg::FIELD_W-1:0] res_word0,
    output logic signed [se2pau_pkg::FIELD_W-1:0] res_word1,
    output logic signed [se2pau_pkg::FIELD_W-1:0] res_word2,
    output logic signed [se2pau_pkg::FIELD_W-1:0] res_word3,
    output logic                              saturated
);
    import se2pau_pkg::*;

    // clip range of a result word
    localparam int SAT_W = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
    localparam sum_t SAT_HI = SUM_W'((longint'(1) <<< (SAT_W - 1)) - 1);
    localparam sum_t SAT_LO = -SAT_HI - SUM_W'(1);
    // rounding half at product scale
    localparam sum_t ROUND_HALF = SUM_W'(longint'(1) <<< (FRAC_BITS - 1));

    // the pipeline never stalls, so an item is taken in every cycle with start high
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // stage 1: operand selection per opcode and products
    // ------------------------------------------------------------------
    word_t mx  [N_WORDS][N_TERMS];
    word_t my  [N_WORDS][N_TERMS];
    logic  mneg[N_WORDS][N_TERMS];
    word_t madd[N_WORDS];

    always_comb
    begin
        for (int w = 0; w < N_WORDS; w++)
        begin
            madd[w] = '0;
            for (int k = 0; k < N_TERMS; k++)
            begin
                mx[w][k]   = '0;
                my[w][k]   = '0;
                mneg[w][k] = 1'b0;
            end
        end
        case (op_t'(opcode))
            OP_COMPOSE:
            begin
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot1;   my[0][1] = b_word1;  mneg[0][1] = 1'b1;
                mx[1][0] = a_rot0;   my[1][0] = b_word1;
                mx[1][1] = a_rot1;   my[1][1] = b_word0;
                mx[2][0] = a_rot0;   my[2][0] = b_word2;
                mx[2][1] = a_rot1;   my[2][1] = b_word3;  madd[2] = a_trans0;
                mx[3][0] = a_rot0;   my[3][0] = b_word3;
                mx[3][1] = a_rot1;   my[3][1] = b_word2;  mneg[3][1] = 1'b1;
                madd[3] = a_trans1;
            end
            OP_COMPOSE_INV:
            begin
                // translation words are formed after the rotation is rounded
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot1;   my[0][1] = b_word1;
                mx[1][0] = a_rot0;   my[1][0] = b_word1;  mneg[1][0] = 1'b1;
                mx[1][1] = a_rot1;   my[1][1] = b_word0;
            end
            OP_POINT:
            begin
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot1;   my[0][1] = b_word1;  madd[0] = a_trans0;
                mx[1][0] = a_rot1;   my[1][0] = b_word0;  mneg[1][0] = 1'b1;
                mx[1][1] = a_rot0;   my[1][1] = b_word1;  madd[1] = a_trans1;
            end
            OP_POINT_INV:
            begin
                // rotation transpose of (x - t), expanded so products stay exact
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot0;   my[0][1] = a_trans0; mneg[0][1] = 1'b1;
                mx[0][2] = a_rot1;   my[0][2] = b_word1;  mneg[0][2] = 1'b1;
                mx[0][3] = a_rot1;   my[0][3] = a_trans1;
                mx[1][0] = a_rot1;   my[1][0] = b_word0;
                mx[1][1] = a_rot1;   my[1][1] = a_trans0; mneg[1][1] = 1'b1;
                mx[1][2] = a_rot0;   my[1][2] = b_word1;
                mx[1][3] = a_rot0;   my[1][3] = a_trans1; mneg[1][3] = 1'b1;
            end
            OP_ADJ:
            begin
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot1;   my[0][1] = b_word1;
                mx[0][2] = a_trans1; my[0][2] = b_word2;
                mx[1][0] = a_rot1;   my[1][0] = b_word0;  mneg[1][0] = 1'b1;
                mx[1][1] = a_rot0;   my[1][1] = b_word1;
                mx[1][2] = a_trans0; my[1][2] = b_word2;  mneg[1][2] = 1'b1;
                madd[2] = b_word2;
            end
            OP_ADJ_T:
            begin
                mx[0][0] = a_rot0;   my[0][0] = b_word0;
                mx[0][1] = a_rot1;   my[0][1] = b_word1;  mneg[0][1] = 1'b1;
                mx[1][0] = a_rot0;   my[1][0] = b_word1;
                mx[1][1] = a_rot1;   my[1][1] = b_word0;
                mx[2][0] = a_trans1; my[2][0] = b_word0;
                mx[2][1] = a_trans0; my[2][1] = b_word1;  mneg[2][1] = 1'b1;
                madd[2] = b_word2;
            end
            default:
            begin
                // reserved: every term stays zero
            end
        endcase
    end

    logic  s1_valid_reg;
    prod_t s1_prod_reg[N_WORDS][N_TERMS];
    logic  s1_neg_reg [N_WORDS][N_TERMS];
    word_t s1_add_reg [N_WORDS];
    logic  s1_inv_reg;
    word_t s1_at0_reg, s1_at1_reg, s1_b2_reg, s1_b3_reg;

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < N_WORDS; w++)
        begin
            s1_add_reg[w] <= madd[w];
            for (int k = 0; k < N_TERMS; k++)
            begin
                s1_prod_reg[w][k] <= PROD_W'(mx[w][k]) * PROD_W'(my[w][k]);
                s1_neg_reg[w][k]  <= mneg[w][k];
            end
        end
        s1_inv_reg <= (op_t'(opcode) == OP_COMPOSE_INV);
        s1_at0_reg <= a_trans0;
        s1_at1_reg <= a_trans1;
        s1_b2_reg  <= b_word2;
        s1_b3_reg  <= b_word3;
    end

    // ------------------------------------------------------------------
    // stage 2: exact sum at product scale, rounding half folded in
    // ------------------------------------------------------------------
    sum_t s2_sum_next[N_WORDS];

    always_comb
    begin
        for (int w = 0; w < N_WORDS; w++)
        begin
            s2_sum_next[w] = (SUM_W'(s1_add_reg[w]) <<< FRAC_BITS) + ROUND_HALF;
            for (int k = 0; k < N_TERMS; k++)
            begin
                if (s1_neg_reg[w][k])
                    s2_sum_next[w] = s2_sum_next[w] - SUM_W'(s1_prod_reg[w][k]);
                else
                    s2_sum_next[w] = s2_sum_next[w] + SUM_W'(s1_prod_reg[w][k]);
            end
        end
    end

    logic  s2_valid_reg;
    sum_t  s2_sum_reg[N_WORDS];
    logic  s2_inv_reg;
    word_t s2_at0_reg, s2_at1_reg, s2_b2_reg, s2_b3_reg;

    always_ff @(posedge clk)
    begin
        s2_sum_reg <= s2_sum_next;
        s2_inv_reg <= s1_inv_reg;
        s2_at0_reg <= s1_at0_reg;
        s2_at1_reg <= s1_at1_reg;
        s2_b2_reg  <= s1_b2_reg;
        s2_b3_reg  <= s1_b3_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: rounding shift and clip
    // ------------------------------------------------------------------
    sum_t  s3_shift[N_WORDS];
    word_t s3_word_next[N_WORDS];
    logic  s3_clip_next[N_WORDS];

    always_comb
    begin
        for (int w = 0; w < N_WORDS; w++)
        begin
            s3_shift[w] = s2_sum_reg[w] >>> FRAC_BITS;
            if (s3_shift[w] > SAT_HI)
            begin
                s3_word_next[w] = SAT_HI[FIELD_W-1:0];
                s3_clip_next[w] = 1'b1;
            end
            else if (s3_shift[w] < SAT_LO)
            begin
                s3_word_next[w] = SAT_LO[FIELD_W-1:0];
                s3_clip_next[w] = 1'b1;
            end
            else
            begin
                s3_word_next[w] = s3_shift[w][FIELD_W-1:0];
                s3_clip_next[w] = 1'b0;
            end
        end
    end

    logic  s3_valid_reg;
    word_t s3_word_reg[N_WORDS];
    logic  s3_clip_reg[N_WORDS];
    logic  s3_inv_reg;
    word_t s3_at0_reg, s3_at1_reg, s3_b2_reg, s3_b3_reg;

    always_ff @(posedge clk)
    begin
        s3_word_reg <= s3_word_next;
        s3_clip_reg <= s3_clip_next;
        s3_inv_reg  <= s2_inv_reg;
        s3_at0_reg  <= s2_at0_reg;
        s3_at1_reg  <= s2_at1_reg;
        s3_b2_reg   <= s2_b2_reg;
        s3_b3_reg   <= s2_b3_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: products on the rounded rotation for the inverse translation
    // ------------------------------------------------------------------
    logic  s4_valid_reg;
    prod_t s4_prod_reg[N_TERMS];
    word_t s4_word_reg[N_WORDS];
    logic  s4_clip_reg[N_WORDS];
    logic  s4_inv_reg;
    word_t s4_at0_reg, s4_at1_reg;

    always_ff @(posedge clk)
    begin
        // r0*b2, r1*b3, r0*b3, r1*b2
        s4_prod_reg[0] <= PROD_W'(s3_word_reg[0]) * PROD_W'(s3_b2_reg);
        s4_prod_reg[1] <= PROD_W'(s3_word_reg[1]) * PROD_W'(s3_b3_reg);
        s4_prod_reg[2] <= PROD_W'(s3_word_reg[0]) * PROD_W'(s3_b3_reg);
        s4_prod_reg[3] <= PROD_W'(s3_word_reg[1]) * PROD_W'(s3_b2_reg);
        s4_word_reg    <= s3_word_reg;
        s4_clip_reg    <= s3_clip_reg;
        s4_inv_reg     <= s3_inv_reg;
        s4_at0_reg     <= s3_at0_reg;
        s4_at1_reg     <= s3_at1_reg;
    end

    // ------------------------------------------------------------------
    // stage 5: inverse translation sums
    // ------------------------------------------------------------------
    logic  s5_valid_reg;
    sum_t  s5_sum_reg[2];
    word_t s5_word_reg[N_WORDS];
    logic  s5_clip_reg[N_WORDS];
    logic  s5_inv_reg;

    always_ff @(posedge clk)
    begin
        // t0 - r0*b2 - r1*b3
        s5_sum_reg[0] <= (SUM_W'(s4_at0_reg) <<< FRAC_BITS) + ROUND_HALF
                       - SUM_W'(s4_prod_reg[0]) - SUM_W'(s4_prod_reg[1]);
        // t1 - r0*b3 + r1*b2
        s5_sum_reg[1] <= (SUM_W'(s4_at1_reg) <<< FRAC_BITS) + ROUND_HALF
                       - SUM_W'(s4_prod_reg[2]) + SUM_W'(s4_prod_reg[3]);
        s5_word_reg   <= s4_word_reg;
        s5_clip_reg   <= s4_clip_reg;
        s5_inv_reg    <= s4_inv_reg;
    end

    // ------------------------------------------------------------------
    // stage 6: round/clip the inverse translation, merge, output register
    // ------------------------------------------------------------------
    sum_t  s6_shift[2];
    word_t s6_word[N_WORDS];
    logic  s6_clip[N_WORDS];

    always_comb
    begin
        s6_word = s5_word_reg;
        s6_clip = s5_clip_reg;
        for (int j = 0; j < 2; j++)
        begin
            s6_shift[j] = s5_sum_reg[j] >>> FRAC_BITS;
            if (s5_inv_reg)
            begin
                if (s6_shift[j] > SAT_HI)
                begin
                    s6_word[j + 2] = SAT_HI[FIELD_W-1:0];
                    s6_clip[j + 2] = 1'b1;
                end
                else if (s6_shift[j] < SAT_LO)
                begin
                    s6_word[j + 2] = SAT_LO[FIELD_W-1:0];
                    s6_clip[j + 2] = 1'b1;
                end
                else
                begin
                    s6_word[j + 2] = s6_shift[j][FIELD_W-1:0];
                    s6_clip[j + 2] = 1'b0;
                end
            end
        end
    end

    logic  out_valid_reg;
    word_t out_word_reg[N_WORDS];
    logic  out_sat_reg;

    always_ff @(posedge clk)
    begin
        out_word_reg <= s6_word;
        out_sat_reg  <= s6_clip[0] | s6_clip[1] | s6_clip[2] | s6_clip[3];
    end

    // valid bits travel with the beat through all six stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    assign done      = out_valid_reg;
    assign res_word0 = out_word_reg[0];
    assign res_word1 = out_word_reg[1];
    assign res_word2 = out_word_reg[2];
    assign res_word3 = out_word_reg[3];
    assign saturated = out_sat_reg;

endmodule

`default_nettype wire
